/* rtl/core/rice_bitstream_decoder_defines.svh */
// Assertion macros for the Rice bitstream decoder.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef RICE_BITSTREAM_DECODER_DEFINES_SVH
`define RICE_BITSTREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check clocked on aclk, muted while reset is held
`define RBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check clocked on aclk, also active during reset
`define RBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBD_ASSERT(lbl, clk, rstn, prop, msg)
`define RBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/rbd_pkg.sv */
// Shared constants for the Rice bitstream decoder.
// No dependencies; imported by rice_bitstream_decoder.
package rbd_pkg;

    // Default width of the saturating quotient counter
    localparam int QUOTIENT_BITS_DEF = 16;

    localparam int BYTE_BITS   = 8;
    localparam int MAX_RES     = 8;
    localparam int RES_CNT_W   = 4;
    localparam int REM_BITS    = 15;
    localparam int REM_GOT_W   = 4;
    localparam int K_W         = 4;
    localparam int VALUE_W     = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_RICE_K      = 1'd0;
    localparam cfg_index_t REG_SIGNED_MODE = 1'd1;

endpackage

/* rtl/core/rice_bitstream_decoder.sv */
// Rice code decoder over an LSB-first byte stream, one byte per request.
// Depends on rbd_pkg and rice_bitstream_decoder_defines.svh.
// Flow: a byte in the input register is walked once the result buffer is free; its
//   values load into the buffer and leave on m_*, one per cycle while m_ready is high.
// Throughput: one byte per cycle while each byte yields one value at most and m_ready
//   is high; more values hold the buffer and input register until the last is taken.
// Reset (aresetn low, synchronous): no partial code, empty buffers, rice_k = 0,
//   signed_mode = 1.
`include "rice_bitstream_decoder_defines.svh"

module rice_bitstream_decoder #(
    parameter int QUOTIENT_BITS = rbd_pkg::QUOTIENT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  rbd_pkg::cfg_index_t                 cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // byte requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rbd_pkg::BYTE_BITS-1:0]       s_data_byte,
    input  logic                                s_restart,
    // decoded values
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rbd_pkg::VALUE_W-1:0]  m_value,
    output logic                                m_saturated,
    output logic                                m_last
);
    import rbd_pkg::*;

    localparam logic [QUOTIENT_BITS-1:0] CNT_MAX = {QUOTIENT_BITS{1'b1}};

    // configuration registers
    logic [K_W-1:0]           k_reg;
    logic                     signed_reg;

    // input register
    logic                     in_valid_reg;
    logic [BYTE_BITS-1:0]     in_byte_reg;
    logic                     in_restart_reg;

    // partial code carried across bytes
    logic                     in_rem_reg;
    logic [QUOTIENT_BITS-1:0] cnt_reg;
    logic                     ovf_reg;
    logic [REM_BITS-1:0]      rbits_reg;
    logic [REM_GOT_W-1:0]     rgot_reg;

    // result buffer, head at slot 0
    logic [RES_CNT_W-1:0]     buf_cnt_reg;
    logic [QUOTIENT_BITS-1:0] cnt_buf_reg  [MAX_RES];
    logic                     ovf_buf_reg  [MAX_RES];
    logic [REM_BITS-1:0]      rem_buf_reg  [MAX_RES];

    // walk results
    logic                     in_rem_next;
    logic [QUOTIENT_BITS-1:0] cnt_next;
    logic                     ovf_next;
    logic [REM_BITS-1:0]      rbits_next;
    logic [REM_GOT_W-1:0]     rgot_next;
    logic [RES_CNT_W-1:0]     res_n;
    logic [QUOTIENT_BITS-1:0] slot_cnt [MAX_RES];
    logic                     slot_ovf [MAX_RES];
    logic [REM_BITS-1:0]      slot_rem [MAX_RES];
    logic                     emit;
    logic                     cur_bit;

    logic                     pop;
    logic                     buf_free;
    logic                     proc_fire;

    logic [REM_BITS-1:0]      rem_mask;
    logic [VALUE_W-1:0]       head_value;

    // handshake control
    assign pop       = m_valid && m_ready;
    assign buf_free  = (buf_cnt_reg == '0) || ((buf_cnt_reg == RES_CNT_W'(1)) && m_ready);
    assign proc_fire = in_valid_reg && buf_free;
    assign s_ready   = !in_valid_reg || proc_fire;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg      <= '0;
            signed_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RICE_K:      k_reg      <= cfg_data[K_W-1:0];
                REG_SIGNED_MODE: signed_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg    <= s_data_byte;
            in_restart_reg <= s_restart;
        end
    end

    // bit walk over the held byte, LSB first
    always_comb begin
        in_rem_next = in_rem_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        rbits_next  = rbits_reg;
        rgot_next   = rgot_reg;
        res_n       = '0;
        emit        = 1'b0;
        cur_bit     = 1'b0;
        for (int i = 0; i < MAX_RES; i++) begin
            slot_cnt[i] = '0;
            slot_ovf[i] = 1'b0;
            slot_rem[i] = '0;
        end
        if (in_restart_reg) begin
            in_rem_next = 1'b0;
            cnt_next    = '0;
            ovf_next    = 1'b0;
            rbits_next  = '0;
            rgot_next   = '0;
        end
        for (int b = 0; b < BYTE_BITS; b++) begin
            cur_bit = in_byte_reg[b];
            emit    = 1'b0;
            if (!in_rem_next) begin
                if (cur_bit) begin
                    // quotient run, saturating
                    if (cnt_next == CNT_MAX) begin
                        ovf_next = 1'b1;
                    end else begin
                        cnt_next = cnt_next + 1'b1;
                    end
                end else begin
                    in_rem_next = 1'b1;
                    rbits_next  = '0;
                    rgot_next   = '0;
                    emit        = (k_reg == '0);
                end
            end else begin
                // one remainder bit, then finish once enough are in
                rbits_next = rbits_next | (REM_BITS'(cur_bit) << rgot_next);
                rgot_next  = rgot_next + 1'b1;
                emit       = (rgot_next >= k_reg);
            end
            if (emit) begin
                slot_cnt[res_n[2:0]] = cnt_next;
                slot_ovf[res_n[2:0]] = ovf_next;
                slot_rem[res_n[2:0]] = rbits_next;
                res_n       = res_n + 1'b1;
                in_rem_next = 1'b0;
                cnt_next    = '0;
                ovf_next    = 1'b0;
                rbits_next  = '0;
                rgot_next   = '0;
            end
        end
    end

    // code state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rem_reg <= 1'b0;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            rbits_reg  <= '0;
            rgot_reg   <= '0;
        end else if (proc_fire) begin
            in_rem_reg <= in_rem_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            rbits_reg  <= rbits_next;
            rgot_reg   <= rgot_next;
        end
    end

    // result buffer fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_cnt_reg <= '0;
        end else if (proc_fire) begin
            buf_cnt_reg <= res_n;
        end else if (pop) begin
            buf_cnt_reg <= buf_cnt_reg - 1'b1;
        end
    end

    // result buffer payload: load all slots or shift toward the head
    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            for (int i = 0; i < MAX_RES; i++) begin
                cnt_buf_reg[i] <= slot_cnt[i];
                ovf_buf_reg[i] <= slot_ovf[i];
                rem_buf_reg[i] <= slot_rem[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                cnt_buf_reg[i] <= cnt_buf_reg[i+1];
                ovf_buf_reg[i] <= ovf_buf_reg[i+1];
                rem_buf_reg[i] <= rem_buf_reg[i+1];
            end
        end
    end

    // value assembly and signed mapping at the head
    assign rem_mask   = REM_BITS'((16'd1 << k_reg) - 16'd1);
    assign head_value = (VALUE_W'(cnt_buf_reg[0]) << k_reg)
                      | VALUE_W'(rem_buf_reg[0] & rem_mask);

    always_comb begin
        if (signed_reg) begin
            if (head_value[0]) begin
                m_value = ~(head_value >> 1);
            end else begin
                m_value = head_value >> 1;
            end
        end else begin
            m_value = head_value;
        end
    end

    assign m_valid     = (buf_cnt_reg != '0);
    assign m_saturated = ovf_buf_reg[0];
    assign m_last      = (buf_cnt_reg == RES_CNT_W'(1));

    // checks
    `RBD_ASSERT(a_buf_cnt_range, aclk, aresetn, buf_cnt_reg <= RES_CNT_W'(MAX_RES), "result count above buffer depth")
    `RBD_ASSERT(a_ovf_means_full, aclk, aresetn, ovf_reg |-> (cnt_reg == CNT_MAX), "overflow flag with counter not full")
    `RBD_ASSERT(a_run_clean, aclk, aresetn, !in_rem_reg |-> ((rbits_reg == '0) && (rgot_reg == '0)), "remainder state dirty while counting ones")
    `RBD_ASSERT(a_rem_bits_bounded, aclk, aresetn, (rbits_reg >> rgot_reg) == '0, "remainder bit set beyond gathered count")
    `RBD_ASSERT_ALWAYS(a_sat_head, aclk, (m_valid && m_saturated) |-> (cnt_buf_reg[0] == CNT_MAX), "saturated result without full quotient")

endmodule

/* tb/tb_rice_bitstream_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rice_bitstream_decoder: directed and random byte streams
// are checked against an in-bench Rice decoder. Depends on rbd_pkg and the RTL.
module tb_rice_bitstream_decoder;
    import rbd_pkg::*;

    localparam int QB = QUOTIENT_BITS_DEF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        logic                      last;
    } decoded_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    cfg_index_t                  cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [BYTE_BITS-1:0]        s_data_byte;
    logic                        s_restart;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [VALUE_W-1:0]   m_value;
    logic                        m_saturated;
    logic                        m_last;

    rice_bitstream_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_restart   (s_restart),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_saturated (m_saturated),
        .m_last      (m_last)
    );

    // Decoder mirror: configuration and partial-code state
    logic [K_W-1:0]       cfg_k = '0;
    logic                 cfg_signed = 1'b1;
    logic                 rem_phase = 1'b0;
    logic [QB-1:0]        quot_cnt = '0;
    logic                 quot_sat = 1'b0;
    logic [REM_BITS-1:0]  rem_acc = '0;
    logic [REM_GOT_W-1:0] rem_cnt = '0;

    decoded_t pending_values[$];
    decoded_t want;

    int  n_errors = 0;
    int  n_bytes  = 0;
    int  n_values = 0;
    int  n_sat    = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(50_000_000);
        $display("rice_bitstream_decoder: mismatch");
        $finish;
    end

    // Walk one byte LSB first and queue the values it finishes
    task automatic predict_byte(input logic [7:0] data, input logic restart);
        decoded_t         vals[$];
        decoded_t         res;
        logic             bit_in;
        logic             done;
        logic [31:0]      raw;
        if (restart) begin
            rem_phase = 1'b0;
            quot_cnt  = '0;
            quot_sat  = 1'b0;
            rem_acc   = '0;
            rem_cnt   = '0;
        end
        for (int b = 0; b < BYTE_BITS; b++) begin
            bit_in = data[b];
            done   = 1'b0;
            if (!rem_phase) begin
                if (bit_in) begin
                    if (quot_cnt == '1)
                        quot_sat = 1'b1;
                    else
                        quot_cnt = quot_cnt + 1'b1;
                end else begin
                    rem_phase = 1'b1;
                    rem_acc   = '0;
                    rem_cnt   = '0;
                    done      = (cfg_k == '0);
                end
            end else begin
                rem_acc = rem_acc | (REM_BITS'(bit_in) << rem_cnt);
                rem_cnt = rem_cnt + 1'b1;
                done    = (rem_cnt >= cfg_k);
            end
            if (done) begin
                raw = (32'(quot_cnt) << cfg_k) | (32'(rem_acc) & ((32'd1 << cfg_k) - 32'd1));
                if (!cfg_signed)
                    res.value = raw;
                else if (raw[0])
                    res.value = ~(raw >> 1);
                else
                    res.value = raw >> 1;
                res.saturated = quot_sat;
                res.last      = 1'b0;
                vals.push_back(res);
                rem_phase = 1'b0;
                quot_cnt  = '0;
                quot_sat  = 1'b0;
                rem_acc   = '0;
                rem_cnt   = '0;
            end
        end
        if (vals.size() > 0) begin
            res      = vals.pop_back();
            res.last = 1'b1;
            vals.push_back(res);
        end
        foreach (vals[i])
            pending_values.push_back(vals[i]);
    endtask

    // Send one byte request; an optional idle burst goes before it
    task automatic send_byte(input logic [7:0] data, input logic restart);
        int gap;
        @(negedge aclk);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= data;
        s_restart   <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(data, restart);
        n_bytes++;
    endtask

    // Stop sending and wait until every queued value has come out
    task automatic drain_values();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_values.size() != 0 && waited < 200_000) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_values.size() != 0) begin
            $error("%0d values never came out", pending_values.size());
            n_errors++;
            pending_values.delete();
        end
        // a byte with no value may still be in the pipeline
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RICE_K)
            cfg_k = data[K_W-1:0];
        else if (idx == REG_SIGNED_MODE)
            cfg_signed = data[0];
    endtask

    task automatic set_config(input int k, input int sgn);
        write_reg(REG_RICE_K, CFG_DATA_W'(k));
        write_reg(REG_SIGNED_MODE, CFG_DATA_W'(sgn));
    endtask

    // Result side: random stall bursts on m_ready
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0)
                stall_left--;
            else if (recv_idle && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            m_ready <= (stall_left == 0);
        end
    end

    // Compare each accepted value with the oldest one queued
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected value %0d (saturated %0b last %0b)",
                       m_value, m_saturated, m_last);
                n_errors++;
            end else begin
                want = pending_values.pop_front();
                n_values++;
                if (want.saturated)
                    n_sat++;
                if (m_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, m_value);
                    n_errors++;
                end
                if (m_saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated, m_saturated);
                    n_errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    n_errors++;
                end
            end
        end
    end

    // Reset values: k = 0, signed mapping on
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        drain_values();
    endtask

    // Widest remainder, unsigned mode, extreme bytes
    task automatic test_register_extremes();
        set_config(15, 0);
        send_byte(8'hFE, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        drain_values();
        set_config(0, 0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        drain_values();
    endtask

    // rice_k lowered while a remainder is half collected
    task automatic test_k_lowered();
        set_config(12, 1);
        send_byte(8'h06, 1'b1);
        drain_values();
        write_reg(REG_RICE_K, CFG_DATA_W'(3));
        send_byte(8'hC3, 1'b0);
        send_byte(8'h5B, 1'b0);
        drain_values();
    endtask

    // Restart drops a partial code that is part way through its remainder
    task automatic test_restart();
        set_config(4, 1);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h3F, 1'b1);
        send_byte(8'h9C, 1'b1);
        send_byte(8'h00, 1'b0);
        drain_values();
    endtask

    // Random streams over a range of settings; the last phase runs without idling
    task automatic test_random_stream();
        int          phase_k[8]   = '{0, 1, 3, 15, 7, 2, 0, 5};
        int          phase_sgn[8] = '{1, 0, 1, 1, 0, 1, 0, 1};
        logic [7:0]  data;
        logic        restart;
        for (int p = 0; p < 8; p++) begin
            set_config(phase_k[p], phase_sgn[p]);
            if (p == 7) begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            for (int i = 0; i < 60; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: data = 8'($urandom_range(0, 255));
                    6, 7:             data = 8'($urandom & $urandom);
                    8:                data = 8'($urandom | $urandom);
                    default:          data = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
                endcase
                restart = ($urandom_range(0, 15) == 0);
                send_byte(data, restart);
                // hold the sender until the result side has caught up
                if (p == 4 && i == 30)
                    drain_values();
            end
            drain_values();
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_RICE_K;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_restart   = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_k_lowered();
        test_restart();
        test_random_stream();

        drain_values();
        repeat (10) @(posedge aclk);
        $display("Sent %0d bytes and checked %0d decoded values (%0d saturated),",
                 n_bytes, n_values, n_sat);
        $display("over rice_k 0..15, both mappings, restarts and mid-code k changes.");
        if (n_errors == 0)
            $display("rice_bitstream_decoder: match");
        else
            $display("rice_bitstream_decoder: mismatch");
        $finish;
    end

endmodule
